// ----- hdl/ddh_pkg.sv -----
// ----------------------------------------------------------------------------
// ddh_pkg
// Shared types and constants for the displacement distance histogram.
// ----------------------------------------------------------------------------
package ddh_pkg;

  localparam int NUM_BINS_DEF   = 1024;
  localparam int COORD_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF = 32;

  localparam int KIND_BITS   = 2;
  localparam int TYPE_BITS   = 3;
  localparam int ADDR_BITS   = 10;
  localparam int STATUS_BITS = 2;
  localparam int OUT_CNT_BITS = 32;
  localparam int WIDTH_BITS  = 16;
  localparam int USE_BITS    = 11;
  // axis differences at or above 2^27 are always beyond
  localparam int AXIS_BITS   = 27;
  localparam int SQ_BITS     = 56;
  localparam int ROOT_BITS   = 28;

  localparam logic [1:0] KIND_ACC   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] CFG_SPECIES = 2'd0;
  localparam logic [1:0] CFG_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_USE     = 2'd2;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_BEYOND  = 2'd1,
    ST_SKIPPED = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SQUARE, S_ROOT, S_DIV, S_READ, S_WRITE, S_OUT
  } state_t;

endpackage

// ----- hdl/displacement_distance_histogram.sv -----
// ----------------------------------------------------------------------------
// displacement_distance_histogram
// Van Hove self-displacement histogram with saturating bin counts.
// ----------------------------------------------------------------------------
// Accumulate items use three squares, a 28-step root and a 28-step divide
// in one shared serial unit. One item at a time, bounded by the memory
// read-modify-write.
// Reset: clearing pass over NUM_BINS entries, one per cycle, no items taken.
// Registers reset to species 1, width 41, 1000 bins.
module displacement_distance_histogram #(
  parameter int NUM_BINS   = ddh_pkg::NUM_BINS_DEF,
  parameter int COORD_BITS = ddh_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = ddh_pkg::COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // kind, atom_type, start_x/y/z, later_x/y/z, bin_address (low bit up)
  input  logic [((2+3+6*COORD_BITS+10+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status, bin_index, bin_count
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ddh_pkg::*;

  localparam int AB = $clog2(NUM_BINS);
  localparam int C0 = 5;

  state_t state, state_next;
  logic [2:0]  species;
  logic [15:0] bin_width;
  logic [10:0] bins_use;
  logic [AB-1:0] addr, init_addr;
  logic [1:0]  kind;
  logic [COUNT_BITS-1:0] rdata, wdata;
  logic we;
  logic dstart, ddone, dfar;
  logic [ROOT_BITS-1:0] didx;
  logic [1:0] st;
  logic [ADDR_BITS-1:0] oidx;
  logic [COUNT_BITS-1:0] ocnt;
  logic [11:0] limit;

  assign limit = (32'(bins_use) < NUM_BINS) ? 12'(bins_use) : 12'(NUM_BINS);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      species <= 3'd1; bin_width <= 16'd41; bins_use <= 11'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPECIES: species   <= cfg_data[2:0];
        CFG_WIDTH:   bin_width <= cfg_data;
        CFG_USE:     bins_use  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  ddh_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BINS)) u_ram (
    .clk(clk), .we(we), .addr(state == S_INIT ? init_addr : addr),
    .wdata(wdata), .rdata(rdata));

  ddh_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk(clk), .rst(rst), .start(dstart),
    .sx(s_tdata[C0 +: COORD_BITS]),
    .sy(s_tdata[C0+COORD_BITS +: COORD_BITS]),
    .sz(s_tdata[C0+2*COORD_BITS +: COORD_BITS]),
    .lx(s_tdata[C0+3*COORD_BITS +: COORD_BITS]),
    .ly(s_tdata[C0+4*COORD_BITS +: COORD_BITS]),
    .lz(s_tdata[C0+5*COORD_BITS +: COORD_BITS]),
    .bin_width(bin_width), .done(ddone), .far(dfar), .index(didx));

  assign s_tready = (state == S_IDLE);
  wire acc = s_tvalid && s_tready;
  assign dstart = acc && s_tdata[1:0] == KIND_ACC && s_tdata[4:2] == species;

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   if (32'(init_addr) == NUM_BINS - 1) state_next = S_IDLE;
      S_IDLE:   if (acc) state_next = dstart ? S_ROOT :
                  (s_tdata[1:0] == KIND_ACC || 32'(s_tdata[C0+6*COORD_BITS +: ADDR_BITS])
                   >= NUM_BINS) ? S_OUT : S_READ;
      S_ROOT:   if (ddone) state_next = (dfar || 32'(didx) >= 32'(limit)) ? S_OUT : S_READ;
      S_READ:   state_next = S_WRITE;
      S_WRITE:  state_next = S_OUT;
      S_OUT:    if (m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0; wdata = rdata;
    if (state == S_INIT) begin
      we = 1'b1; wdata = '0;
    end else if (state == S_WRITE) begin
      if (kind == KIND_ACC) begin
        we = 1'b1; wdata = (&rdata) ? rdata : rdata + COUNT_BITS'(1);
      end else if (kind == KIND_CLEAR) begin
        we = 1'b1; wdata = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; init_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_INIT) init_addr <= init_addr + AB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      kind <= s_tdata[1:0];
      addr <= AB'(s_tdata[C0+6*COORD_BITS +: ADDR_BITS]);
      ocnt <= '0;
      if (s_tdata[1:0] != KIND_ACC) begin
        st <= ST_READ; oidx <= s_tdata[C0+6*COORD_BITS +: ADDR_BITS];
      end else begin
        st <= ST_SKIPPED; oidx <= '0;
      end
    end
    if (state == S_ROOT && ddone) begin
      addr <= AB'(didx);
      if (dfar || 32'(didx) >= 32'(limit)) begin
        st <= ST_BEYOND;
        oidx <= (dfar || didx > 28'd1023) ? 10'd1023 : didx[9:0];
      end else begin
        st <= ST_COUNTED; oidx <= didx[9:0];
      end
    end
    if (state == S_WRITE) ocnt <= (kind == KIND_ACC) ? wdata : rdata;
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {4'b0000, OUT_CNT_BITS'(ocnt), oidx, st};
endmodule

// ----- hdl/ddh_ram.sv -----
// ----------------------------------------------------------------------------
// ddh_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ddh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- hdl/ddh_dist.sv -----
// ----------------------------------------------------------------------------
// ddh_dist
// Displacement to bin index: squares, bit-serial integer root, serial divide.
// ----------------------------------------------------------------------------
module ddh_dist #(
  parameter int COORD_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [COORD_BITS-1:0]        sx, sy, sz, lx, ly, lz,
  input  logic [ddh_pkg::WIDTH_BITS-1:0]      bin_width,
  output logic                                done,
  output logic                                far,
  output logic [ddh_pkg::ROOT_BITS-1:0]       index
);
  import ddh_pkg::*;

  localparam int DB = COORD_BITS + 1;

  typedef enum logic [2:0] {P_IDLE, P_SQ, P_SUM, P_ROOT, P_DIV} phase_t;

  phase_t phase;
  logic [DB-1:0] ax, ay, az;
  logic [SQ_BITS-1:0] sq, sumsq, rem;
  logic [ROOT_BITS-1:0] root, quo;
  logic [4:0] step;
  logic [1:0] axis;
  logic [WIDTH_BITS:0] drem;
  logic [AXIS_BITS-1:0] msel;
  logic [SQ_BITS-1:0] trial;
  logic [WIDTH_BITS:0] dtry;
  logic [WIDTH_BITS-1:0] w;

  function automatic logic [DB-1:0] absd(input logic signed [COORD_BITS-1:0] a,
                                         input logic signed [COORD_BITS-1:0] b);
    logic signed [DB-1:0] d;
    d = DB'(a) - DB'(b);
    return d[DB-1] ? DB'(-d) : DB'(d);
  endfunction

  always_comb begin
    unique case (axis)
      2'd0:    msel = AXIS_BITS'(ax);
      2'd1:    msel = AXIS_BITS'(ay);
      default: msel = AXIS_BITS'(az);
    endcase
    trial = SQ_BITS'({rem, sumsq[2*step +: 2]}) - SQ_BITS'({root, 2'b01});
    w     = (bin_width == '0) ? WIDTH_BITS'(1) : bin_width;
    dtry  = {drem[WIDTH_BITS-1:0], root[ROOT_BITS-1 - step]} - {1'b0, w};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: if (start) begin
          ax <= absd(lx, sx); ay <= absd(ly, sy); az <= absd(lz, sz);
          phase <= P_SQ; axis <= 2'd0; sumsq <= '0;
        end
        P_SQ: begin
          if ((ax >> AXIS_BITS) != '0 || (ay >> AXIS_BITS) != '0
              || (az >> AXIS_BITS) != '0) begin
            far <= 1'b1; done <= 1'b1; phase <= P_IDLE;
          end else begin
            sq <= SQ_BITS'(msel) * SQ_BITS'(msel);
            phase <= P_SUM;
          end
        end
        P_SUM: begin
          sumsq <= sumsq + sq;
          if (axis == 2'd2) begin
            phase <= P_ROOT; step <= 5'(ROOT_BITS - 1); rem <= '0; root <= '0;
          end else begin
            axis <= axis + 2'd1; phase <= P_SQ;
          end
        end
        P_ROOT: begin
          if (!trial[SQ_BITS-1]) begin
            rem <= trial; root <= {root[ROOT_BITS-2:0], 1'b1};
          end else begin
            rem <= SQ_BITS'({rem, sumsq[2*step +: 2]});
            root <= {root[ROOT_BITS-2:0], 1'b0};
          end
          if (step == '0) begin
            phase <= P_DIV; drem <= '0;
          end else step <= step - 5'd1;
        end
        default: begin
          if (!dtry[WIDTH_BITS]) begin
            drem <= dtry; quo <= {quo[ROOT_BITS-2:0], 1'b1};
          end else begin
            drem <= {drem[WIDTH_BITS-1:0], root[ROOT_BITS-1 - step]};
            quo <= {quo[ROOT_BITS-2:0], 1'b0};
          end
          if (step == 5'(ROOT_BITS - 1)) begin
            far <= 1'b0; done <= 1'b1; phase <= P_IDLE;
          end else step <= step + 5'd1;
        end
      endcase
    end
  end

  // quotient is complete when done is raised with far low
  assign index = quo;
endmodule
